// File: hw/rtl/ps2a_pkg.sv
// Shared constants, types and key tables for the PS/2 scancode to ASCII queue.
// Used by ps2a_key_decode, ps2a_char_queue and the top level; depends on nothing.
package ps2a_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int FILL_W      = 7;

    // Item opcodes carried on the input tuser
    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // Set-1 key codes
    localparam logic [6:0] K_ENTER  = 7'h1C;
    localparam logic [6:0] K_BKSP   = 7'h0E;
    localparam logic [6:0] K_TAB    = 7'h0F;
    localparam logic [6:0] K_LSHIFT = 7'h2A;
    localparam logic [6:0] K_RSHIFT = 7'h36;
    localparam logic [6:0] K_CTRL   = 7'h1D;
    localparam logic [6:0] K_ALT    = 7'h38;
    localparam logic [6:0] K_CAPS   = 7'h3A;

    localparam logic [6:0] CH_NL = 7'h0A;
    localparam logic [6:0] CH_BS = 7'h08;
    localparam logic [6:0] CH_HT = 7'h09;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } mod_flags_t;

    typedef struct packed {
        logic step;   // an item is processed this cycle
        logic push;
        logic pop;
        logic flush;
    } q_cmd_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [CNT_W-1:0] count;
    } q_stat_t;

    function automatic logic [6:0] lo_char(input logic [5:0] idx);
        logic [6:0] c;
        case (idx)
            6'h02: c = 7'("1");   6'h03: c = 7'("2");   6'h04: c = 7'("3");
            6'h05: c = 7'("4");   6'h06: c = 7'("5");   6'h07: c = 7'("6");
            6'h08: c = 7'("7");   6'h09: c = 7'("8");   6'h0A: c = 7'("9");
            6'h0B: c = 7'("0");   6'h0C: c = 7'("-");   6'h0D: c = 7'("=");
            6'h10: c = 7'("q");   6'h11: c = 7'("w");   6'h12: c = 7'("e");
            6'h13: c = 7'("r");   6'h14: c = 7'("t");   6'h15: c = 7'("y");
            6'h16: c = 7'("u");   6'h17: c = 7'("i");   6'h18: c = 7'("o");
            6'h19: c = 7'("p");   6'h1A: c = 7'("[");   6'h1B: c = 7'("]");
            6'h1E: c = 7'("a");   6'h1F: c = 7'("s");   6'h20: c = 7'("d");
            6'h21: c = 7'("f");   6'h22: c = 7'("g");   6'h23: c = 7'("h");
            6'h24: c = 7'("j");   6'h25: c = 7'("k");   6'h26: c = 7'("l");
            6'h27: c = 7'(";");   6'h28: c = 7'h27;     6'h29: c = 7'h60;
            6'h2B: c = 7'h5C;     6'h2C: c = 7'("z");   6'h2D: c = 7'("x");
            6'h2E: c = 7'("c");   6'h2F: c = 7'("v");   6'h30: c = 7'("b");
            6'h31: c = 7'("n");   6'h32: c = 7'("m");   6'h33: c = 7'(",");
            6'h34: c = 7'(".");   6'h35: c = 7'("/");   6'h37: c = 7'("*");
            6'h39: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] hi_char(input logic [5:0] idx);
        logic [6:0] c;
        case (idx)
            6'h02: c = 7'("!");   6'h03: c = 7'("@");   6'h04: c = 7'("#");
            6'h05: c = 7'("$");   6'h06: c = 7'("%");   6'h07: c = 7'("^");
            6'h08: c = 7'("&");   6'h09: c = 7'("*");   6'h0A: c = 7'("(");
            6'h0B: c = 7'(")");   6'h0C: c = 7'("_");   6'h0D: c = 7'("+");
            6'h10: c = 7'("Q");   6'h11: c = 7'("W");   6'h12: c = 7'("E");
            6'h13: c = 7'("R");   6'h14: c = 7'("T");   6'h15: c = 7'("Y");
            6'h16: c = 7'("U");   6'h17: c = 7'("I");   6'h18: c = 7'("O");
            6'h19: c = 7'("P");   6'h1A: c = 7'("{");   6'h1B: c = 7'("}");
            6'h1E: c = 7'("A");   6'h1F: c = 7'("S");   6'h20: c = 7'("D");
            6'h21: c = 7'("F");   6'h22: c = 7'("G");   6'h23: c = 7'("H");
            6'h24: c = 7'("J");   6'h25: c = 7'("K");   6'h26: c = 7'("L");
            6'h27: c = 7'(":");   6'h28: c = 7'h22;     6'h29: c = 7'("~");
            6'h2B: c = 7'("|");   6'h2C: c = 7'("Z");   6'h2D: c = 7'("X");
            6'h2E: c = 7'("C");   6'h2F: c = 7'("V");   6'h30: c = 7'("B");
            6'h31: c = 7'("N");   6'h32: c = 7'("M");   6'h33: c = 7'("<");
            6'h34: c = 7'(">");   6'h35: c = 7'("?");
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/ps2a_key_decode.sv
// Set-1 scancode decoder: modifier flag update and ASCII lookup for one byte.
// Combinational; depends on ps2a_pkg for key codes, tables and mod_flags_t.
module ps2a_key_decode (
    input  logic                 [7:0] scancode,
    input  ps2a_pkg::mod_flags_t       flags_cur,
    output ps2a_pkg::mod_flags_t       flags_nxt,
    output logic                 [6:0] ch,
    output logic                       ch_valid
);

    logic [6:0] key;
    logic       down;

    assign key  = scancode[6:0];
    assign down = ~scancode[7];

    always_comb
    begin
        flags_nxt = flags_cur;
        if (key inside {ps2a_pkg::K_LSHIFT, ps2a_pkg::K_RSHIFT})
        begin
            flags_nxt.shift = down;
        end
        else if (key == ps2a_pkg::K_CTRL)
        begin
            flags_nxt.ctrl = down;
        end
        else if (key == ps2a_pkg::K_ALT)
        begin
            flags_nxt.alt = down;
        end
        else if (key == ps2a_pkg::K_CAPS && down)
        begin
            flags_nxt.caps = ~flags_cur.caps;
        end
    end

    // Lookup uses the updated shift state; codes 0x40 and up have no entry
    always_comb
    begin
        ch = 7'h00;
        if (down)
        begin
            case (key)
                ps2a_pkg::K_ENTER: ch = ps2a_pkg::CH_NL;
                ps2a_pkg::K_BKSP:  ch = ps2a_pkg::CH_BS;
                ps2a_pkg::K_TAB:   ch = ps2a_pkg::CH_HT;
                default:
                begin
                    if (!key[6])
                    begin
                        ch = (flags_nxt.shift ^ flags_nxt.caps)
                             ? ps2a_pkg::hi_char(key[5:0])
                             : ps2a_pkg::lo_char(key[5:0]);
                    end
                end
            endcase
        end
    end

    assign ch_valid = (ch != 7'h00);

endmodule

// File: hw/rtl/ps2a_char_queue.sv
// Character FIFO: QUEUE_DEPTH x 7 memory with wrapping pointers and fill count.
// Read data is registered on each processed item; depends on ps2a_pkg.
module ps2a_char_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ps2a_pkg::q_cmd_t        cmd,
    input  logic              [6:0] wdata,
    output logic              [6:0] rdata,
    output ps2a_pkg::q_stat_t       stat
);

    localparam int PW = ps2a_pkg::PTR_W;
    localparam int CW = ps2a_pkg::CNT_W;

    logic [6:0]    mem [ps2a_pkg::QUEUE_DEPTH];
    logic [6:0]    rdata_reg;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          empty;
    logic          full;
    logic          push_ok;
    logic          pop_ok;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(ps2a_pkg::QUEUE_DEPTH));
    assign push_ok = cmd.step & cmd.push & ~full;
    assign pop_ok  = cmd.step & cmd.pop & ~empty;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (cmd.step && cmd.flush)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            count_next  = '0;
        end
        else if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(ps2a_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(ps2a_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Read the head on every step; the top level masks it unless a pop hit
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign rdata       = rdata_reg;
    assign stat.empty  = empty;
    assign stat.full   = full;
    assign stat.count  = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ps2a_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_full_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && cmd.push && full && !cmd.flush |=> $stable(wr_ptr_reg) && $stable(count_reg))
        else $error("push into full queue changed state");

endmodule

// File: hw/rtl/ps2_scancode_to_ascii_queue_unit.sv
// Top level of the PS/2 set-1 scancode to ASCII decoder with character queue.
// Instantiates ps2a_key_decode and ps2a_char_queue; depends on ps2a_pkg.
//
// Each input transfer carries an opcode on tuser (scan byte, pop, flush) and a
// scancode on tdata; every item produces exactly one result transfer. The block
// takes one item per clock while the output drains: an input register feeds the
// decode, flag update and queue update, which land in the result register.
// The queue is a QUEUE_DEPTH x 7 memory written at one address and read at one
// address per cycle with registered read data; it needs no clearing pass after
// reset. Modifier flags, caps and the fill level on a result are the state after
// that item.
module ps2_scancode_to_ascii_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] scancode
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] pop_valid, [7:1] pop_char, [8] dropped, [15:9] fill_level,
    // [16] shift_held, [17] ctrl_held, [18] alt_held, [19] caps_on, [23:20] zero
    output logic [23:0] m_axis_tdata
);

    logic                 in_valid_reg, in_valid_next;
    logic [1:0]           in_op_reg;
    logic [7:0]           in_sc_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_pop_reg;
    logic                 out_drop_reg;
    logic                 adv;
    logic                 s_fire;
    logic                 is_scan;
    ps2a_pkg::mod_flags_t flags_reg;
    ps2a_pkg::mod_flags_t flags_dec;
    logic [6:0]           dec_ch;
    logic                 dec_ch_valid;
    ps2a_pkg::q_cmd_t     q_cmd;
    ps2a_pkg::q_stat_t    q_stat;
    logic [6:0]           q_rdata;
    logic [6:0]           pop_char;

    // Advance the input stage when the result register is free or being taken
    assign adv           = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | adv;
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign is_scan       = (in_op_reg == ps2a_pkg::OP_SCAN);

    ps2a_key_decode u_decode (
        .scancode  (in_sc_reg),
        .flags_cur (flags_reg),
        .flags_nxt (flags_dec),
        .ch        (dec_ch),
        .ch_valid  (dec_ch_valid)
    );

    assign q_cmd.step  = adv;
    assign q_cmd.push  = is_scan & dec_ch_valid;
    assign q_cmd.pop   = (in_op_reg == ps2a_pkg::OP_POP);
    assign q_cmd.flush = (in_op_reg == ps2a_pkg::OP_FLUSH);

    ps2a_char_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (q_cmd),
        .wdata (dec_ch),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv && is_scan)
            begin
                flags_reg <= flags_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_op_reg <= s_axis_tuser;
            in_sc_reg <= s_axis_tdata;
        end
        if (adv)
        begin
            out_pop_reg  <= q_cmd.pop & ~q_stat.empty;
            out_drop_reg <= q_cmd.push & q_stat.full;
        end
    end

    // Flags and queue count only move on an advance, which also reloads the
    // result register, so they always describe the item held there.
    assign pop_char      = out_pop_reg ? q_rdata : 7'h00;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000,
                            flags_reg.caps, flags_reg.alt, flags_reg.ctrl, flags_reg.shift,
                            ps2a_pkg::FILL_W'(q_stat.count),
                            out_drop_reg, pop_char, out_pop_reg};

    a_pop_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_pop_reg && out_drop_reg))
        else $error("pop and drop on the same result");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_drop_reg |-> q_stat.full)
        else $error("drop reported with queue not full");

    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        adv && q_cmd.flush |=> q_stat.empty)
        else $error("queue not empty after flush");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a full pipeline");

endmodule
